// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the barometer pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int QueueDepth = 2;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] RegOversampling = 3'd0;
  localparam logic [2:0] RegCalWordA     = 3'd1;
  localparam logic [2:0] RegCalWordB     = 3'd2;
  localparam logic [2:0] RegCalWordC     = 3'd3;
  localparam logic [2:0] RegCalWordD     = 3'd4;
  localparam logic [2:0] RegCalWordE     = 3'd5;

  localparam logic [1:0]  OversamplingReset = 2'd3;
  localparam logic [31:0] CalWordAReset     = 32'd4229374066;
  localparam logic [31:0] CalWordBReset     = 32'd2209663304;
  localparam logic [31:0] CalWordCReset     = 32'd1595041080;
  localparam logic [31:0] CalWordDReset     = 32'd2103667;
  localparam logic [31:0] CalWordEReset     = 32'd148427254;

  // Datasheet constants.
  localparam logic [31:0]        PressScale = 32'd50000;
  localparam logic signed [28:0] B6Offset   = 29'sd4000;
  localparam logic signed [31:0] CoefP2     = 32'sd3038;
  localparam logic signed [31:0] CoefP1     = -32'sd7357;
  localparam logic signed [44:0] CoefP0     = 45'sd3791;
  localparam logic [31:0]        B4Offset   = 32'd32768;

  // Shared multiplier and divider sizes.
  localparam int MulAW   = 48;
  localparam int MulBW   = 32;
  localparam int ProdW   = MulAW + MulBW;
  localparam int DivW    = 32;
  localparam int DivStep = 2;

  typedef struct packed {
    logic [18:0] raw_pressure;
    logic [15:0] raw_temperature;
  } item_t;

  typedef struct packed {
    logic [1:0]  oversampling;
    logic [31:0] cal_word_a;
    logic [31:0] cal_word_b;
    logic [31:0] cal_word_c;
    logic [31:0] cal_word_d;
    logic [31:0] cal_word_e;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_M0, S_W0, S_D1, S_WD1, S_M1, S_W1, S_M2, S_W2, S_M3, S_W3,
    S_M4, S_W4, S_M5, S_W5, S_X3, S_M6, S_W6, S_M7, S_W7, S_D2, S_WD2,
    S_M8, S_W8, S_M9, S_W9, S_M10, S_W10, S_F1, S_F2, S_OUT
  } state_t;

  // Signed division by 2^k that truncates toward zero.
  function automatic logic signed [ProdW-1:0] trunc_shr(input logic signed [ProdW-1:0] x,
                                                        input int unsigned k);
    logic signed [ProdW-1:0] bias;
    bias = x[ProdW-1] ? ((ProdW'(1) << k) - ProdW'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ===== rtl/barometer_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometer_pressure_compensation
// Integer pressure compensation for a barometric sensor, stream in and out.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw temperature reading and one raw
// pressure reading; each produces exactly one output transaction with the
// compensated pressure in pascals, or zero with the error flag set when a
// divisor of the datasheet formula is zero. The back end works on one reading
// at a time: the steps run in order through one shared 48 x 32 multiplier
// (eleven products) and one shared radix-4 divider (two quotients), and that
// sequence sets the rate at which readings pass. A small input queue keeps
// accepting readings while the back end works, and the output register holds
// a finished result while the next reading is already under way; the back end
// only waits when that register still holds a result nobody has taken. The
// oversampling setting and the five packed calibration words sit on the APB
// port at byte addresses 0, 4, 8, 12, 16 and 20 and must only be changed while
// no reading is in flight.
// ----------------------------------------------------------------------------
module barometer_pressure_compensation import bpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] raw_temperature, [34:16] raw_pressure
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pressure_pa
  output logic        m_axis_tuser,   // [0] div_error
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // Unpack the input payload; the padding bits above the fields are unused.
  assign in_item.raw_temperature = s_axis_tdata[15:0];
  assign in_item.raw_pressure    = s_axis_tdata[34:16];

  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front end: buffers accepted readings so the input never waits on the
  // back end unless the queue is full.
  bpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  // Back end: runs the compensation and owns the output register.
  bpc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_pressure (m_axis_tdata),
    .out_err      (m_axis_tuser)
  );

endmodule

// ===== rtl/bpc_regs.sv =====
// ----------------------------------------------------------------------------
// bpc_regs
// APB configuration registers: oversampling setting and calibration words.
// ----------------------------------------------------------------------------
module bpc_regs import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oversampling <= OversamplingReset;
      cfg.cal_word_a   <= CalWordAReset;
      cfg.cal_word_b   <= CalWordBReset;
      cfg.cal_word_c   <= CalWordCReset;
      cfg.cal_word_d   <= CalWordDReset;
      cfg.cal_word_e   <= CalWordEReset;
    end else if (wr_en) begin
      case (paddr[4:2])
        RegOversampling: cfg.oversampling <= pwdata[1:0];
        RegCalWordA:     cfg.cal_word_a   <= pwdata;
        RegCalWordB:     cfg.cal_word_b   <= pwdata;
        RegCalWordC:     cfg.cal_word_c   <= pwdata;
        RegCalWordD:     cfg.cal_word_d   <= pwdata;
        RegCalWordE:     cfg.cal_word_e   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegOversampling: prdata = {30'd0, cfg.oversampling};
      RegCalWordA:     prdata = cfg.cal_word_a;
      RegCalWordB:     prdata = cfg.cal_word_b;
      RegCalWordC:     prdata = cfg.cal_word_c;
      RegCalWordD:     prdata = cfg.cal_word_d;
      RegCalWordE:     prdata = cfg.cal_word_e;
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bpc_queue.sv =====
// ----------------------------------------------------------------------------
// bpc_queue
// Front end: accepts reading pairs and holds them until the core takes one.
// ----------------------------------------------------------------------------
module bpc_queue import bpc_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_pop,
  output item_t out_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CntW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bpc_mul.sv =====
// ----------------------------------------------------------------------------
// bpc_mul
// Shared signed multiplier, 48 x 32 bits, done as two 24-bit partial products.
// ----------------------------------------------------------------------------
module bpc_mul import bpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mul_req_t                req,
  output logic signed [ProdW-1:0] prod,
  output logic                    done
);

  localparam int HalfW = MulAW / 2;

  logic signed [MulAW-1:0]       ar;
  logic signed [MulBW-1:0]       br;
  logic signed [HalfW+MulBW:0]   lo;
  logic signed [HalfW+MulBW-1:0] hi;
  logic                          v0;
  logic                          v1;

  assign hi = $signed(ar[MulAW-1:HalfW]) * br;

  always_ff @(posedge clk) begin
    if (req.start) begin
      ar <= $signed(req.a);
      br <= $signed(req.b);
    end
    if (v0) begin
      lo <= $signed({1'b0, ar[HalfW-1:0]}) * br;
    end
    if (v1) begin
      prod <= (ProdW'(hi) <<< HalfW) + ProdW'(lo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= req.start;
      v1   <= v0;
      done <= v1;
    end
  end

endmodule

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic [DivW-1:0] quo,
  output logic            done
);

  localparam int Iters = DivW / DivStep;
  localparam int CntW  = $clog2(Iters);

  logic [DivW:0]   rem;
  logic [DivW-1:0] den;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   rem_n;
  logic [DivW-1:0] quo_n;

  always_comb begin
    rem_n = rem;
    quo_n = quo;
    for (int i = 0; i < DivStep; i++) begin
      rem_n = {rem_n[DivW-1:0], quo_n[DivW-1]};
      quo_n = {quo_n[DivW-2:0], 1'b0};
      if (rem_n >= {1'b0, den}) begin
        rem_n    = rem_n - {1'b0, den};
        quo_n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_n;
      quo <= quo_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Iters - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core
// Back end: sequences the compensation steps over the shared multiplier and
// divider, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module bpc_core import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pressure,
  output logic        out_err
);

  state_t state, state_next;

  mul_req_t                mreq;
  div_req_t                dreq;
  logic signed [ProdW-1:0] prod;
  logic                    mul_done;
  logic [DivW-1:0]         quo;
  logic                    div_done;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  logic [1:0]         oss;

  // Datapath registers.
  logic [15:0]        ut;
  logic [18:0]        up;
  logic signed [17:0] x1;
  logic               dneg;
  logic signed [28:0] b6;
  logic [42:0]        sq;
  logic signed [47:0] t1;
  logic signed [49:0] x3a;
  logic [31:0]        b3lo;
  logic signed [30:0] u1;
  logic signed [42:0] u2;
  logic [31:0]        x3lo;
  logic [16:0]        b4;
  logic [31:0]        b7;
  logic signed [31:0] p;
  logic [47:0]        f1;
  logic signed [42:0] f1b;
  logic signed [31:0] f2;
  logic signed [44:0] sum;
  logic [31:0]        res;
  logic               err;

  // Combinational helpers.
  logic signed [16:0]       diff;
  logic signed [18:0]       den_c;
  logic [16:0]              mc_abs;
  logic [18:0]              den_abs;
  logic signed [27:0]       x2;
  logic signed [ProdW-1:0]  b3_full;
  logic [15:0]              scale;
  logic [31:0]              b7a;
  logic [31:0]              q;
  logic signed [23:0]       ps;
  logic                     load_out;

  assign oss = cfg.oversampling;
  assign ac1 = $signed(cfg.cal_word_a[15:0]);
  assign ac2 = $signed(cfg.cal_word_a[31:16]);
  assign ac3 = $signed(cfg.cal_word_b[15:0]);
  assign ac4 = cfg.cal_word_b[31:16];
  assign ac5 = cfg.cal_word_c[15:0];
  assign ac6 = cfg.cal_word_c[31:16];
  assign b1  = $signed(cfg.cal_word_d[15:0]);
  assign b2  = $signed(cfg.cal_word_d[31:16]);
  assign mc  = $signed(cfg.cal_word_e[15:0]);
  assign md  = $signed(cfg.cal_word_e[31:16]);

  assign diff    = $signed({1'b0, ut}) - $signed({1'b0, ac6});
  assign den_c   = 19'(x1) + 19'(md);
  assign mc_abs  = mc[15] ? (~{mc[15], mc} + 17'd1) : {1'b0, mc};
  assign den_abs = den_c[18] ? (~den_c + 19'd1) : den_c;
  assign x2      = dneg ? -$signed(quo[27:0]) : $signed(quo[27:0]);
  assign b3_full = trunc_shr((ProdW'(x3a) <<< oss) + ProdW'(2), 2);
  assign scale   = 16'(PressScale >> oss);
  assign b7a     = {13'd0, up} - b3lo;
  assign q       = b7[31] ? {quo[30:0], 1'b0} : quo;
  assign ps      = 24'(trunc_shr(ProdW'(p), 8));
  assign load_out = !out_valid || out_ready;

  bpc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .prod (prod),
    .done (mul_done)
  );

  bpc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .quo  (quo),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_valid) state_next = S_M0;
      S_M0:    state_next = S_W0;
      S_W0:    if (mul_done) state_next = S_D1;
      S_D1:    state_next = (den_c == '0) ? S_OUT : S_WD1;
      S_WD1:   if (div_done) state_next = S_M1;
      S_M1:    state_next = S_W1;
      S_W1:    if (mul_done) state_next = S_M2;
      S_M2:    state_next = S_W2;
      S_W2:    if (mul_done) state_next = S_M3;
      S_M3:    state_next = S_W3;
      S_W3:    if (mul_done) state_next = S_M4;
      S_M4:    state_next = S_W4;
      S_W4:    if (mul_done) state_next = S_M5;
      S_M5:    state_next = S_W5;
      S_W5:    if (mul_done) state_next = S_X3;
      S_X3:    state_next = S_M6;
      S_M6:    state_next = S_W6;
      S_W6:    if (mul_done) state_next = S_M7;
      S_M7:    state_next = (b4 == '0) ? S_OUT : S_W7;
      S_W7:    if (mul_done) state_next = S_D2;
      S_D2:    state_next = S_WD2;
      S_WD2:   if (div_done) state_next = S_M8;
      S_M8:    state_next = S_W8;
      S_W8:    if (mul_done) state_next = S_M9;
      S_M9:    state_next = S_W9;
      S_W9:    if (mul_done) state_next = S_M10;
      S_M10:   state_next = S_W10;
      S_W10:   if (mul_done) state_next = S_F1;
      S_F1:    state_next = S_F2;
      S_F2:    state_next = S_OUT;
      S_OUT:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      S_IDLE: q_pop = q_valid;
      S_M0: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(diff);
        mreq.b     = {16'd0, ac5};
      end
      S_D1: begin
        dreq.start = (den_c != '0);
        dreq.num   = {4'd0, mc_abs, 11'd0};
        dreq.den   = {13'd0, den_abs};
      end
      S_M1: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(b6);
        mreq.b     = 32'(b6);
      end
      S_M2: begin
        mreq.start = 1'b1;
        mreq.a     = {5'd0, sq};
        mreq.b     = 32'(b2);
      end
      S_M3: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(b6);
        mreq.b     = 32'(ac2);
      end
      S_M4: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(b6);
        mreq.b     = 32'(ac3);
      end
      S_M5: begin
        mreq.start = 1'b1;
        mreq.a     = {5'd0, sq};
        mreq.b     = 32'(b1);
      end
      S_M6: begin
        mreq.start = 1'b1;
        mreq.a     = {16'd0, x3lo + B4Offset};
        mreq.b     = {16'd0, ac4};
      end
      S_M7: begin
        mreq.start = (b4 != '0);
        mreq.a     = {16'd0, b7a};
        mreq.b     = {16'd0, scale};
      end
      S_D2: begin
        dreq.start = 1'b1;
        dreq.num   = b7[31] ? b7 : {b7[30:0], 1'b0};
        dreq.den   = {15'd0, b4};
      end
      S_M8: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(ps);
        mreq.b     = 32'(ps);
      end
      S_M9: begin
        mreq.start = 1'b1;
        mreq.a     = f1;
        mreq.b     = CoefP2;
      end
      S_M10: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(p);
        mreq.b     = CoefP1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ut <= q_item.raw_temperature;
        up <= q_item.raw_pressure;
      end
      S_W0:  if (mul_done) x1 <= 18'(trunc_shr(prod, 15));
      S_D1: begin
        dneg <= mc[15] ^ den_c[18];
        res  <= '0;
        err  <= 1'b1;
      end
      S_WD1: if (div_done) b6 <= 29'(x1) + 29'(x2) - B6Offset;
      S_W1:  if (mul_done) sq <= prod[54:12];
      S_W2:  if (mul_done) t1 <= 48'(trunc_shr(prod, 11));
      S_W3:  if (mul_done) x3a <= (50'(ac1) <<< 2) + 50'(t1) + 50'(trunc_shr(prod, 11));
      S_M4:  b3lo <= b3_full[31:0];
      S_W4:  if (mul_done) u1 <= 31'(trunc_shr(prod, 13));
      S_W5:  if (mul_done) u2 <= 43'(trunc_shr(prod, 16));
      S_X3:  x3lo <= 32'(trunc_shr(ProdW'(u1) + ProdW'(u2) + ProdW'(2), 2));
      S_W6:  if (mul_done) b4 <= prod[31:15];
      S_M7: begin
        res <= '0;
        err <= 1'b1;
      end
      S_W7:  if (mul_done) b7 <= prod[31:0];
      S_WD2: if (div_done) p <= $signed(q);
      S_W8:  if (mul_done) f1 <= prod[47:0];
      S_W9:  if (mul_done) f1b <= 43'(trunc_shr(prod, 16));
      S_W10: if (mul_done) f2 <= 32'(trunc_shr(prod, 16));
      S_F1:  sum <= 45'(f1b) + 45'(f2) + CoefP0;
      S_F2: begin
        res <= p + 32'(trunc_shr(ProdW'(sum), 4));
        err <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && load_out) begin
      out_pressure <= res;
      out_err      <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== test/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the ports of the pressure compensation block and checks its output.
// ----------------------------------------------------------------------------
// It tracks register writes on the APB port and computes the expected pressure
// for each accepted reading. It then compares each output transaction with the
// oldest expected one.
// ----------------------------------------------------------------------------
module bpc_checker import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pressures_owed
);

  typedef struct packed {
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } pressure_t;

  cfg_t      cal;
  pressure_t owed_q[$];

  function automatic longint sext16(input logic [15:0] w);
    return longint'($signed(w));
  endfunction

  // Datasheet integer compensation with truncating signed division.
  function automatic pressure_t compensate(input logic [15:0] ut_raw,
                                           input logic [18:0] up_raw,
                                           input cfg_t c);
    pressure_t   r;
    longint      ut, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint      x1, x2, x3, b3, b6, den, p;
    logic [31:0] b4, b7, q, prod;
    int unsigned oss;
    oss = c.oversampling;
    ut  = longint'(ut_raw);
    ac1 = sext16(c.cal_word_a[15:0]);
    ac2 = sext16(c.cal_word_a[31:16]);
    ac3 = sext16(c.cal_word_b[15:0]);
    ac4 = longint'(c.cal_word_b[31:16]);
    ac5 = longint'(c.cal_word_c[15:0]);
    ac6 = longint'(c.cal_word_c[31:16]);
    b1  = sext16(c.cal_word_d[15:0]);
    b2  = sext16(c.cal_word_d[31:16]);
    mc  = sext16(c.cal_word_e[15:0]);
    md  = sext16(c.cal_word_e[31:16]);
    r.pressure_pa = '0;
    r.div_error   = 1'b1;
    x1  = ((ut - ac6) * ac5) / 32768;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b6 = (x1 + x2) - 4000;
    x1 = (b2 * ((b6 * b6) / 4096)) / 2048;
    x2 = (ac2 * b6) / 2048;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
    x1 = (ac3 * b6) / 8192;
    x2 = (b1 * ((b6 * b6) / 4096)) / 65536;
    x3 = ((x1 + x2) + 2) / 4;
    prod = ac4[31:0] * 32'(x3 + 32768);
    b4 = prod >> 15;
    if (b4 == 0) return r;
    b7 = {13'd0, up_raw} - b3[31:0];
    b7 = b7 * (32'd50000 >> oss);
    if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
    else q = (b7 / b4) * 32'd2;
    p  = longint'($signed(q));
    x1 = (p / 256) * (p / 256);
    x1 = (x1 * 3038) / 65536;
    x2 = (-7357 * p) / 65536;
    p  = p + (x1 + x2 + 3791) / 16;
    r.pressure_pa = p[31:0];
    r.div_error   = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;
  initial pressures_owed = 0;

  always @(posedge clk) begin
    pressure_t want;
    if (rst) begin
      cal <= '{OversamplingReset, CalWordAReset, CalWordBReset, CalWordCReset,
               CalWordDReset, CalWordEReset};
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegOversampling: cal.oversampling <= pwdata[1:0];
          RegCalWordA:     cal.cal_word_a   <= pwdata;
          RegCalWordB:     cal.cal_word_b   <= pwdata;
          RegCalWordC:     cal.cal_word_c   <= pwdata;
          RegCalWordD:     cal.cal_word_d   <= pwdata;
          RegCalWordE:     cal.cal_word_e   <= pwdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        owed_q.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[34:16], cal));
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          report("unexpected transaction", m_axis_tdata, '0);
        end else begin
          want = owed_q.pop_front();
          if (m_axis_tdata !== want.pressure_pa)
            report("pressure_pa", m_axis_tdata, want.pressure_pa);
          if (m_axis_tuser !== want.div_error)
            report("div_error", 32'(m_axis_tuser), 32'(want.div_error));
        end
      end
    end
    pressures_owed <= owed_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the barometer pressure compensation block.
// ----------------------------------------------------------------------------
// Readings go in through phases of calibration settings: reset values, the
// datasheet example, all zeros (division by zero), all ones, a zero ac4,
// and random words. The sender and receiver idle at random except in two
// quiet phases; the checker predicts and compares each output transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import bpc_pkg::*;

  // Index past the last register; writes there must be ignored.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int         CycleLimit = 400000;
  localparam int         Drain = 200;   // comfortably above the time one reading takes

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  mismatches;
  int  pressures_owed;
  int  cycles = 0;
  bit  quiet = 1'b0;   // phases with no idling on either side
  int  readings_out = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  barometer_pressure_compensation dut (.*);

  bpc_checker checker_i (.*);

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // A write runs the setup phase, then the access phase, then leaves the bus idle.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_calibration(input logic [1:0] oss, input logic [31:0] a,
                                  input logic [31:0] b, input logic [31:0] c,
                                  input logic [31:0] d, input logic [31:0] e);
    reg_write(RegOversampling, {30'd0, oss});
    reg_write(RegCalWordA, a);
    reg_write(RegCalWordB, b);
    reg_write(RegCalWordC, c);
    reg_write(RegCalWordD, d);
    reg_write(RegCalWordE, e);
  endtask

  // Offers one reading and returns at the clock edge where it is accepted.
  // The ready is checked mid-cycle, so the edge itself carries no race.
  task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, up, ut};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  // Outside the quiet phases the receiver stalls at random per transaction; once
  // it holds off long so the input queue fills and the block stops accepting.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (readings_out == 150) stall = 800;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      @(posedge clk);
      readings_out++;
      m_axis_tready <= 1'b0;
    end
  end

  // Waits for the block to drain before the registers change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pressures_owed == 0);
    repeat (Drain) @(posedge clk);
  endtask

  initial begin
    logic [31:0] w [5];
    logic [15:0] ac6;
    logic [15:0] ut;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed readings at the reset calibration: field extremes and the
    // datasheet example pair.
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    send_reading(16'd0, 19'h7FFFF);
    send_reading(16'd27898, 19'd23843);
    send_reading(16'h5555, 19'h2AAAA);
    send_reading(16'hAAAA, 19'h55555);
    send_reading(16'd24000, 19'd300000);

    for (int phase = 0; phase < 9; phase++) begin
      settle();
      quiet = (phase == 3 || phase == 7);
      case (phase)
        0: load_calibration(2'd0, 32'hFFB8_0198, 32'h7FE5_C7D1, 32'h5A71_7FF5,
                            32'h0004_182E, 32'h0B34_DDF9);
        // ac5 and md of zero make the first divisor zero.
        1: load_calibration(2'd1, '0, '0, '0, '0, '0);
        2: load_calibration(2'd2, '1, '1, '1, '1, '1);
        // ac4 of zero makes b4 zero.
        3: load_calibration(2'd3, $urandom, {16'd0, 16'($urandom)}, $urandom,
                            $urandom, $urandom);
        default: begin
          for (int i = 0; i < 5; i++) w[i] = $urandom;
          load_calibration(2'($urandom_range(0, 3)), w[0], w[1], w[2], w[3], w[4]);
        end
      endcase
      // A write past the last register must leave the settings alone.
      if (phase == 4) reg_write(RegUnused, $urandom);
      if (phase == 0) send_reading(16'd27898, 19'd23843);
      ac6 = checker_i.cal.cal_word_c[31:16];
      for (int n = 0; n < 65; n++) begin
        // Half the temperatures sit near ac6 where the formula behaves like a
        // real sensor; the rest cover the whole field.
        if (n[0]) ut = 16'($urandom);
        else ut = ac6 + 16'($urandom_range(0, 2047)) - 16'd1024;
        send_reading(ut, 19'($urandom));
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpc_pkg.sv
rtl/bpc_regs.sv
rtl/bpc_queue.sv
rtl/bpc_mul.sv
rtl/bpc_div.sv
rtl/bpc_core.sv
rtl/barometer_pressure_compensation.sv
test/bpc_checker.sv
test/tb_top.sv
